// ----- sv/tlex_pkg.sv -----
// tlex_pkg: shared types and constants for the token lexer.
// Token kind codes, result token struct, push bundle and character constants.
// No dependencies; compiled first.
package tlex_pkg;

    // Default width of the offset and run-length counters
    localparam int OFFSET_BITS_DEF = 16;

    // Width of the offset and length fields on the result channel
    localparam int FIELD_W = 16;

    // Result queue depth; one byte may push two tokens
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int PUSH_MAX    = 2;

    // Token kinds
    typedef enum logic [3:0] {
        KIND_ILLEGAL = 4'd0,
        KIND_END     = 4'd1,
        KIND_IDENT   = 4'd2,
        KIND_INT     = 4'd3,
        KIND_ASSIGN  = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_COMMA   = 4'd6,
        KIND_SEMI    = 4'd7,
        KIND_LPAREN  = 4'd8,
        KIND_RPAREN  = 4'd9,
        KIND_LBRACE  = 4'd10,
        KIND_RBRACE  = 4'd11,
        KIND_FN      = 4'd12,
        KIND_LET     = 4'd13
    } t_kind;

    // Characters the lexer looks at
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result token
    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [7:0]         first;
        logic               last;
    } t_token;

    // Tokens produced by one byte, in order; count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

// ----- sv/tlex_if.sv -----
// tlex_if: valid/ready channel interfaces for the token lexer.
// tlex_byte_if carries text bytes, tlex_token_if carries result tokens.
// Depends on nothing; compiled after tlex_pkg.
interface tlex_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface tlex_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  first_byte;
    logic        last;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output first_byte, output last,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input first_byte, input last,
                    output ready);
endinterface

// ----- sv/tlex_scan.sv -----
// tlex_scan: lexer state (offset, open run, keyword prefix) and per-byte
// token generation. Depends on tlex_pkg.
module tlex_scan #(
    parameter int OFFSET_BITS = tlex_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output tlex_pkg::t_push   o_push
);

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_IDENT = 2'd1,
        RUN_INT   = 2'd2
    } t_run;

    typedef enum logic [2:0] {
        KW_NONE = 3'd0,
        KW_F    = 3'd1,
        KW_FN   = 3'd2,
        KW_L    = 3'd3,
        KW_LE   = 3'd4,
        KW_LET  = 3'd5
    } t_kw;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFS_ONE = OFFSET_BITS'(1);

    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    t_run                   r_run, n_run;
    logic [OFFSET_BITS-1:0] r_run_start, n_run_start;
    logic [OFFSET_BITS-1:0] r_run_len, n_run_len;
    logic [7:0]             r_run_first, n_run_first;
    t_kw                    r_kw, n_kw;

    logic       is_alpha, is_digit, is_skip, is_end, cont;
    logic       emit_run, emit_byte;
    t_kw        kw_step, kw_first;
    tlex_pkg::t_kind run_kind_out, byte_kind;
    tlex_pkg::t_token run_tok, byte_tok;
    logic [OFFSET_BITS-1:0] offset_inc, len_inc;
    logic [31:0] run_start32, run_len32, offset32;

    // Byte classes
    always_comb begin
        is_alpha = (i_byte >= 8'h61 && i_byte <= 8'h7A) ||
                   (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                   (i_byte == tlex_pkg::CH_US);
        is_digit = (i_byte >= 8'h30 && i_byte <= 8'h39);
        is_skip  = (i_byte == tlex_pkg::CH_SPACE) || (i_byte == tlex_pkg::CH_LF);
        is_end   = (i_byte == tlex_pkg::CH_NUL);
    end

    // Punctuation decode
    always_comb begin
        unique case (i_byte)
            tlex_pkg::CH_ASSIGN: byte_kind = tlex_pkg::KIND_ASSIGN;
            tlex_pkg::CH_PLUS:   byte_kind = tlex_pkg::KIND_PLUS;
            tlex_pkg::CH_COMMA:  byte_kind = tlex_pkg::KIND_COMMA;
            tlex_pkg::CH_SEMI:   byte_kind = tlex_pkg::KIND_SEMI;
            tlex_pkg::CH_LPAREN: byte_kind = tlex_pkg::KIND_LPAREN;
            tlex_pkg::CH_RPAREN: byte_kind = tlex_pkg::KIND_RPAREN;
            tlex_pkg::CH_LBRACE: byte_kind = tlex_pkg::KIND_LBRACE;
            tlex_pkg::CH_RBRACE: byte_kind = tlex_pkg::KIND_RBRACE;
            default:             byte_kind = tlex_pkg::KIND_ILLEGAL;
        endcase
    end

    // Keyword prefix tracking
    always_comb begin
        kw_step = KW_NONE;
        if (r_kw == KW_F && i_byte == tlex_pkg::CH_N) kw_step = KW_FN;
        if (r_kw == KW_L && i_byte == tlex_pkg::CH_E) kw_step = KW_LE;
        if (r_kw == KW_LE && i_byte == tlex_pkg::CH_T) kw_step = KW_LET;
        kw_first = KW_NONE;
        if (i_byte == tlex_pkg::CH_F) kw_first = KW_F;
        if (i_byte == tlex_pkg::CH_L) kw_first = KW_L;
    end

    // Saturating increments
    assign offset_inc = (r_offset == OFS_MAX) ? OFS_MAX : r_offset + OFS_ONE;
    assign len_inc    = (r_run_len == OFS_MAX) ? OFS_MAX : r_run_len + OFS_ONE;

    // Run continuation and token emission
    always_comb begin
        cont = ((r_run == RUN_IDENT) && (is_alpha || is_digit)) ||
               ((r_run == RUN_INT) && is_digit);
        emit_run  = (r_run != RUN_NONE) && !cont;
        emit_byte = !cont && (is_end || !(is_skip || is_alpha || is_digit));

        if (r_run == RUN_INT) begin
            run_kind_out = tlex_pkg::KIND_INT;
        end else if (r_kw == KW_FN) begin
            run_kind_out = tlex_pkg::KIND_FN;
        end else if (r_kw == KW_LET) begin
            run_kind_out = tlex_pkg::KIND_LET;
        end else begin
            run_kind_out = tlex_pkg::KIND_IDENT;
        end

        run_start32 = 32'(r_run_start);
        run_len32   = 32'(r_run_len);
        offset32    = 32'(r_offset);

        run_tok.kind   = run_kind_out;
        run_tok.start  = run_start32[tlex_pkg::FIELD_W-1:0];
        run_tok.length = run_len32[tlex_pkg::FIELD_W-1:0];
        run_tok.first  = r_run_first;
        run_tok.last   = !emit_byte;

        byte_tok.kind   = is_end ? tlex_pkg::KIND_END : byte_kind;
        byte_tok.start  = offset32[tlex_pkg::FIELD_W-1:0];
        byte_tok.length = is_end ? '0 : tlex_pkg::FIELD_W'(1);
        byte_tok.first  = i_byte;
        byte_tok.last   = 1'b1;

        o_push.count = i_valid ? ({1'b0, emit_run} + {1'b0, emit_byte}) : 2'd0;
        o_push.tok0  = emit_run ? run_tok : byte_tok;
        o_push.tok1  = byte_tok;
    end

    // Next state
    always_comb begin
        n_offset    = r_offset;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_run_first = r_run_first;
        n_kw        = r_kw;
        if (cont) begin
            n_run_len = len_inc;
            n_kw      = (r_run == RUN_IDENT) ? kw_step : KW_NONE;
            n_offset  = offset_inc;
        end else if (is_end) begin
            n_offset    = '0;
            n_run       = RUN_NONE;
            n_run_start = '0;
            n_run_len   = '0;
            n_run_first = '0;
            n_kw        = KW_NONE;
        end else if (is_alpha || is_digit) begin
            n_run       = is_digit ? RUN_INT : RUN_IDENT;
            n_run_start = r_offset;
            n_run_len   = OFS_ONE;
            n_run_first = i_byte;
            n_kw        = is_digit ? KW_NONE : kw_first;
            n_offset    = offset_inc;
        end else begin
            n_run     = RUN_NONE;
            n_run_len = '0;
            n_kw      = KW_NONE;
            n_offset  = offset_inc;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_run       <= RUN_NONE;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_run_first <= '0;
            r_kw        <= KW_NONE;
        end else if (i_valid) begin
            r_offset    <= n_offset;
            r_run       <= n_run;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_run_first <= n_run_first;
            r_kw        <= n_kw;
        end
    end

endmodule

// ----- sv/tlex_queue.sv -----
// tlex_queue: small result queue that takes up to two tokens per cycle
// and hands out one per transaction. Depends on tlex_pkg.
module tlex_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlex_pkg::t_push  i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output tlex_pkg::t_token o_token
);

    localparam int AW = tlex_pkg::QUEUE_AW;
    localparam logic [AW:0] SPACE_LIMIT = (AW+1)'(tlex_pkg::QUEUE_DEPTH - tlex_pkg::PUSH_MAX);

    tlex_pkg::t_token r_mem [tlex_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_count, n_count;
    logic          pop;
    logic [AW-1:0] wr_next;

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd];
    assign o_space = (r_count <= SPACE_LIMIT);
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + AW'(1);

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr + AW'(i_push.count);
        n_rd    = pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + (AW+1)'(i_push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Token storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

endmodule

// ----- sv/token_lexer_core.sv -----
// token_lexer_core: streaming lexer top level: input byte register,
// scanner and result queue. Depends on tlex_pkg, tlex_if, tlex_scan, tlex_queue.
//
//   channel   direction  payload                                        per transaction
//   i_text    in         text_byte                                      one source byte
//   o_token   out        token_kind, start_offset, token_length,        one token
//                        first_byte, last
//
// A byte is taken every cycle while the result queue has room for two
// tokens; it is lexed while it sits in the input register, and its tokens
// are written to the queue at the first edge that finds that room.
// A byte that closes a run and gives a token of its own yields two tokens,
// which leave the queue in two transactions. A stall on o_token drops
// i_text.ready once the queue holds more than two tokens while a byte waits
// in the input register. Reset is synchronous and clears the offset, the
// open run and the queue.
module token_lexer_core #(
    parameter int OFFSET_BITS = tlex_pkg::OFFSET_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tlex_byte_if.sink    i_text,
    tlex_token_if.source o_token
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             space;
    logic             advance;
    tlex_pkg::t_push  push;
    tlex_pkg::t_token head;

    assign advance      = r_in_valid && space;
    assign i_text.ready = !r_in_valid || advance;

    // Input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    tlex_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    tlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_token.valid),
        .i_ready (o_token.ready),
        .o_token (head)
    );

    // Result channel fields
    assign o_token.token_kind   = head.kind;
    assign o_token.start_offset = head.start;
    assign o_token.token_length = head.length;
    assign o_token.first_byte   = head.first;
    assign o_token.last         = head.last;

endmodule

// ----- verif/tb_token_lexer_core.sv -----
// tb_token_lexer_core: self-checking testbench for the streaming token lexer.
// Predicts each token from the bytes it sends and checks every result in order.
// Depends on tlex_pkg, tlex_if and token_lexer_core.
module tb_token_lexer_core;

    // Predictor widths and limits
    localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PRINT_LIMIT  = 100;
    localparam int          LONG_RUN_LEN = 60;

    // Character ranges used by the classifier and the text generator
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7A;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {RUN_NONE, RUN_IDENT, RUN_INT} t_run;
    typedef enum logic [2:0] {KW_NONE, KW_F, KW_FN, KW_L, KW_LE, KW_LET} t_kw;

    logic clk;
    logic rst_n;

    tlex_byte_if  text_if();
    tlex_token_if tok_if();

    token_lexer_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_if),
        .o_token (tok_if)
    );

    // Predicted lexer state
    logic [15:0] next_offset;
    logic [15:0] run_start;
    logic [15:0] run_len;
    logic [7:0]  run_first;
    t_run        run_state;
    t_kw         kw_state;

    tlex_pkg::t_token expected_tokens[$];

    int error_count    = 0;
    int tokens_checked = 0;
    int bytes_sent     = 0;
    int idle_cycles    = 0;

    // Idle percentages and no-idle stretches for both channels
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_calm     = 0;
    int recv_calm     = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Lexer predictor
    // ---------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) ||
               b == tlex_pkg::CH_US;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == OFFSET_MAX) ? v : v + 16'd1;
    endfunction

    function automatic t_kw kw_advance(input t_kw s, input logic [7:0] b);
        if (s == KW_F && b == tlex_pkg::CH_N) return KW_FN;
        if (s == KW_L && b == tlex_pkg::CH_E) return KW_LE;
        if (s == KW_LE && b == tlex_pkg::CH_T) return KW_LET;
        return KW_NONE;
    endfunction

    function automatic tlex_pkg::t_kind punct_kind(input logic [7:0] b);
        case (b)
            tlex_pkg::CH_ASSIGN: return tlex_pkg::KIND_ASSIGN;
            tlex_pkg::CH_PLUS:   return tlex_pkg::KIND_PLUS;
            tlex_pkg::CH_COMMA:  return tlex_pkg::KIND_COMMA;
            tlex_pkg::CH_SEMI:   return tlex_pkg::KIND_SEMI;
            tlex_pkg::CH_LPAREN: return tlex_pkg::KIND_LPAREN;
            tlex_pkg::CH_RPAREN: return tlex_pkg::KIND_RPAREN;
            tlex_pkg::CH_LBRACE: return tlex_pkg::KIND_LBRACE;
            tlex_pkg::CH_RBRACE: return tlex_pkg::KIND_RBRACE;
            default:             return tlex_pkg::KIND_ILLEGAL;
        endcase
    endfunction

    function automatic tlex_pkg::t_token make_token(input tlex_pkg::t_kind kind,
                                                    input logic [15:0] start,
                                                    input logic [15:0] length,
                                                    input logic [7:0] first);
        tlex_pkg::t_token tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = length;
        tok.first  = first;
        tok.last   = 1'b0;
        return tok;
    endfunction

    function automatic void reset_lexer();
        next_offset = '0;
        run_start   = '0;
        run_len     = '0;
        run_first   = '0;
        run_state   = RUN_NONE;
        kw_state    = KW_NONE;
    endfunction

    // Advance the predicted state by one byte and queue the tokens it gives
    function automatic void lex_byte(input logic [7:0] b);
        tlex_pkg::t_token toks[$];
        tlex_pkg::t_kind  kind;
        bit               cont;
        if (run_state != RUN_NONE) begin
            cont = is_digit(b) || (run_state == RUN_IDENT && is_word_char(b));
            if (cont) begin
                run_len     = sat_inc(run_len);
                kw_state    = (run_state == RUN_IDENT) ? kw_advance(kw_state, b) : KW_NONE;
                next_offset = sat_inc(next_offset);
                return;
            end
            // byte does not continue the run: close it first
            kind = tlex_pkg::KIND_INT;
            if (run_state == RUN_IDENT) begin
                kind = (kw_state == KW_FN) ? tlex_pkg::KIND_FN :
                       (kw_state == KW_LET) ? tlex_pkg::KIND_LET : tlex_pkg::KIND_IDENT;
            end
            toks.push_back(make_token(kind, run_start, run_len, run_first));
            run_state = RUN_NONE;
            run_len   = '0;
            kw_state  = KW_NONE;
        end

        if (b == tlex_pkg::CH_NUL) begin
            toks.push_back(make_token(tlex_pkg::KIND_END, next_offset, '0, '0));
            reset_lexer();
        end else if (b == tlex_pkg::CH_SPACE || b == tlex_pkg::CH_LF) begin
            next_offset = sat_inc(next_offset);
        end else if (is_word_char(b) || is_digit(b)) begin
            run_state   = is_digit(b) ? RUN_INT : RUN_IDENT;
            run_start   = next_offset;
            run_len     = 16'd1;
            run_first   = b;
            kw_state    = (b == tlex_pkg::CH_F) ? KW_F :
                          (b == tlex_pkg::CH_L) ? KW_L : KW_NONE;
            next_offset = sat_inc(next_offset);
        end else begin
            toks.push_back(make_token(punct_kind(b), next_offset, 16'd1, b));
            next_offset = sat_inc(next_offset);
        end

        if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
        foreach (toks[i]) expected_tokens.push_back(toks[i]);
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("[%0t] ERROR token %0d: %s", $time,
                                                 tokens_checked, msg);
    endtask

    always @(posedge clk) begin : token_check
        tlex_pkg::t_token want;
        if (rst_n && tok_if.valid && tok_if.ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, kind 0x%0h start 0x%0h",
                                          tok_if.token_kind, tok_if.start_offset));
            end else begin
                want = expected_tokens.pop_front();
                if (tok_if.token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind got 0x%0h expected 0x%0h",
                                              tok_if.token_kind, want.kind));
                if (tok_if.start_offset !== want.start)
                    report_mismatch($sformatf("start_offset got 0x%0h expected 0x%0h",
                                              tok_if.start_offset, want.start));
                if (tok_if.token_length !== want.length)
                    report_mismatch($sformatf("token_length got 0x%0h expected 0x%0h",
                                              tok_if.token_length, want.length));
                if (tok_if.first_byte !== want.first)
                    report_mismatch($sformatf("first_byte got 0x%0h expected 0x%0h",
                                              tok_if.first_byte, want.first));
                if (tok_if.last !== want.last)
                    report_mismatch($sformatf("last got %b expected %b",
                                              tok_if.last, want.last));
            end
            tokens_checked++;
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((text_if.valid && text_if.ready) || (tok_if.valid && tok_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout, %0d tokens still pending", $time,
                         expected_tokens.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Token channel back-pressure
    always @(negedge clk) begin
        if (recv_calm > 0) begin
            recv_calm     <= recv_calm - 1;
            tok_if.ready  <= 1'b1;
        end else begin
            if ($urandom_range(99) < 2) recv_calm <= $urandom_range(40, 10);
            tok_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            if ($urandom_range(99) < 2) send_calm = $urandom_range(40, 10);
            while ($urandom_range(99) < send_idle_pct) begin
                text_if.valid = 1'b0;
                @(negedge clk);
            end
        end
        text_if.valid     = 1'b1;
        text_if.text_byte = b;
        do @(posedge clk); while (!text_if.ready);
        lex_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Letters, underscore and, for later positions, digits; biased to keyword letters
    function automatic logic [7:0] pick_word_char(input bit allow_digit);
        case ($urandom_range(allow_digit ? 5 : 4))
            0: return 8'($urandom_range(CH_LC_Z, CH_LC_A));
            1: return 8'($urandom_range(CH_UC_Z, CH_UC_A));
            2: return tlex_pkg::CH_US;
            3, 4: begin
                case ($urandom_range(4))
                    0: return tlex_pkg::CH_F;
                    1: return tlex_pkg::CH_N;
                    2: return tlex_pkg::CH_L;
                    3: return tlex_pkg::CH_E;
                    default: return tlex_pkg::CH_T;
                endcase
            end
            default: return pick_digit();
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(7))
            0: return tlex_pkg::CH_ASSIGN;
            1: return tlex_pkg::CH_PLUS;
            2: return tlex_pkg::CH_COMMA;
            3: return tlex_pkg::CH_SEMI;
            4: return tlex_pkg::CH_LPAREN;
            5: return tlex_pkg::CH_RPAREN;
            6: return tlex_pkg::CH_LBRACE;
            default: return tlex_pkg::CH_RBRACE;
        endcase
    endfunction

    // Keywords, every punctuation byte but plus, run closed by punctuation, end token
    task automatic test_directed_tokens();
        send_str("let f=fn(x,_Z){42};");
        send_byte(tlex_pkg::CH_NUL);
    endtask

    // High bytes, newline, integer closed by a letter, end flushing an open run
    task automatic test_edge_bytes();
        send_byte(8'h80);
        send_byte(tlex_pkg::CH_LF);
        send_byte(8'hFF);
        send_str("9z");
        send_byte(tlex_pkg::CH_NUL);
    endtask

    // Sender holds off until every pending token has come back
    task automatic test_pause_on_drain();
        send_str("a+b");
        text_if.valid = 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        @(negedge clk);
        send_byte(tlex_pkg::CH_SEMI);
        send_byte(tlex_pkg::CH_NUL);
    endtask

    // Mostly well-formed token text with noise mixed in
    task automatic test_random_text(input int n_bytes);
        int target;
        int pick;
        int len;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                if ($urandom_range(1)) send_str("fn");
                else send_str("let");
            end else if (pick < 30) begin
                len = $urandom_range(6, 1);
                send_byte(pick_word_char(1'b0));
                repeat (len - 1) send_byte(pick_word_char(1'b1));
            end else if (pick < 45) begin
                repeat ($urandom_range(5, 1)) send_byte(pick_digit());
            end else if (pick < 65) begin
                send_byte(pick_punct());
            end else if (pick < 79) begin
                send_byte($urandom_range(1) ? tlex_pkg::CH_SPACE : tlex_pkg::CH_LF);
            end else if (pick < 89) begin
                send_byte(8'($urandom_range(255, 1)));
            end else if (pick < 93) begin
                send_byte(8'($urandom));
            end else if (pick < 97) begin
                send_byte(tlex_pkg::CH_NUL);
            end else begin
                send_byte(8'($urandom_range(255, 128)));
            end
        end
    endtask

    // One long identifier closed by punctuation, then an integer closed by a space
    task automatic test_long_run();
        send_byte(tlex_pkg::CH_NUL);
        send_byte(pick_word_char(1'b0));
        repeat (LONG_RUN_LEN) send_byte(pick_word_char(1'b1));
        send_byte(tlex_pkg::CH_PLUS);
        send_byte(pick_digit());
        send_byte(tlex_pkg::CH_SPACE);
        send_byte(tlex_pkg::CH_NUL);
    endtask

    initial begin
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = '0;
        reset_lexer();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // sender idles often less than the receiver
        send_idle_pct = 31;
        recv_idle_pct = 74;
        test_directed_tokens();
        test_edge_bytes();
        test_pause_on_drain();
        test_random_text(530);

        // receiver idles less than the sender
        send_idle_pct = 74;
        recv_idle_pct = 31;
        test_random_text(530);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(530);
        test_long_run();

        text_if.valid = 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
